// ===== rtl/fddr_pkg.sv =====
`default_nettype none

package fddr_pkg;

    // Frame geometry limits and field widths.
    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_ROWS   = 2048;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned IDX_W      = 20;
    localparam int unsigned COL_W      = 10;
    localparam int unsigned ROW_W      = 11;
    localparam int unsigned FW_W       = 11;
    localparam int unsigned RC_W       = 12;
    localparam int unsigned SH_W       = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    // Checkerboard words that are flattened before repacking.
    localparam logic [WORD_W-1:0] CHECKER_A    = 32'h18e3_20e4;
    localparam logic [WORD_W-1:0] CHECKER_B    = 32'h20e4_18e3;
    localparam logic [WORD_W-1:0] CHECKER_FLAT = 32'h18e3_18e3;
    localparam logic [WORD_W-1:0] FIELD_MASK   = 32'h001f_001f;

    // Register reset values.
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 11'd640;
    localparam logic [RC_W-1:0] ROW_COUNT_RST   = 12'd480;
    localparam logic [SH_W-1:0] RED_SHIFT_RST   = 5'd11;
    localparam logic [SH_W-1:0] GREEN_SHIFT_RST = 5'd6;
    localparam logic [SH_W-1:0] BLUE_SHIFT_RST  = 5'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH = 3'd0,
        CFG_ROW_COUNT   = 3'd1,
        CFG_RED_SHIFT   = 3'd2,
        CFG_GREEN_SHIFT = 3'd3,
        CFG_BLUE_SHIFT  = 3'd4
    } t_cfg_index;

    // One word in flight between the store read and the result register.
    typedef struct packed {
        logic [WORD_W-1:0] pixel;
        logic [IDX_W-1:0]  index;
        logic [COL_W-1:0]  x;
        logic [ROW_W-1:0]  y;
        logic              frame_done;
    } t_word_ctx;

    // One result transaction.
    typedef struct packed {
        logic              changed;
        logic [WORD_W-1:0] converted_word;
        logic [IDX_W-1:0]  word_index;
        logic              frame_done;
        logic              dirty_valid;
        logic [9:0]        dirty_x0;
        logic [10:0]       dirty_y0;
        logic [10:0]       dirty_x1;
        logic [11:0]       dirty_y1;
    } t_result;

    // Repack the three color fields of both pixels.
    function automatic logic [WORD_W-1:0] repack(
        input logic [WORD_W-1:0] p,
        input logic [SH_W-1:0]   red_sh,
        input logic [SH_W-1:0]   green_sh,
        input logic [SH_W-1:0]   blue_sh
    );
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] g;
        logic [WORD_W-1:0] b;
        r = (p >> red_sh) & FIELD_MASK;
        g = ((p >> green_sh) & FIELD_MASK) << 5;
        b = ((p >> blue_sh) & FIELD_MASK) << 10;
        return r | g | b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/frame_diff_dirty_rect_unit.sv =====
`default_nettype none
// Frame difference and dirty rectangle unit.
// Input channel (i_in_valid / o_in_stall): one 32-bit framebuffer word per
// transaction, in raster order, two 16-bit pixels per word.
// Output channel (o_out_valid / i_out_stall): one result per input word with
// the changed flag, the repacked word, the word index and, on the last word of
// a frame, the dirty rectangle of all changed positions in that frame.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index (frame
// width, row count, three color shifts); write only while the unit is idle.
// From input acceptance a word passes through the previous-frame store read into
// the compare stage, then through compare, repack and the bounding box update
// into the output register. Throughput is one word per cycle outside the clearing
// sweep and while the receiver does not stall; the store reads the entry of each
// accepted word and writes back each changed word leaving the compare stage, and a
// word that reads the entry of the leaving word takes the data by forwarding.
// After reset the unit sweeps the 2^20-entry store to zero, one entry per cycle,
// with o_in_stall high throughout; configuration writes are taken during this sweep.
// When the receiver stalls, the result holds in the output register, one more
// word can wait in the compare stage, and then o_in_stall rises.
module frame_diff_dirty_rect_unit
    import fddr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [WORD_W-1:0]     i_pixel_word,
    // Output channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_changed,
    output logic [WORD_W-1:0]          o_converted_word,
    output logic [IDX_W-1:0]           o_word_index,
    output logic                       o_frame_done,
    output logic                       o_dirty_valid,
    output logic [9:0]                 o_dirty_x0,
    output logic [10:0]                o_dirty_y0,
    output logic [10:0]                o_dirty_x1,
    output logic [11:0]                o_dirty_y1
);

    // Configuration registers.
    logic [FW_W-1:0] r_frame_width;
    logic [RC_W-1:0] r_row_count;
    logic [SH_W-1:0] r_red_shift;
    logic [SH_W-1:0] r_green_shift;
    logic [SH_W-1:0] r_blue_shift;

    // Raster position of the next word.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    // Store clearing sweep.
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_addr;

    // Previous-frame store.
    logic [WORD_W-1:0] mem_frame [2**IDX_W];
    logic [WORD_W-1:0] r_rd_data;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // Compare stage.
    logic              r_s1_valid;
    t_word_ctx         r_s1;
    t_word_ctx         n_s1;
    logic              r_s1_fwd;
    logic [WORD_W-1:0] r_fwd_data;

    // Bounding box of changed positions in the current frame.
    logic [COL_W-1:0] r_min_x;
    logic [ROW_W-1:0] r_min_y;
    logic [COL_W-1:0] r_max_x;
    logic [ROW_W-1:0] r_max_y;
    logic             r_any;
    logic [COL_W-1:0] n_min_x;
    logic [ROW_W-1:0] n_min_y;
    logic [COL_W-1:0] n_max_x;
    logic [ROW_W-1:0] n_max_y;
    logic             n_any;

    // Output register.
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    // Handshake and datapath nets.
    logic              in_accept;
    logic              out_ready;
    logic              s1_adv;
    logic [FW_W-1:0]   eff_width;
    logic [RC_W-1:0]   eff_rows;
    logic [COL_W-1:0]  words_per_row;
    logic [IDX_W:0]    addr_sum;
    logic [IDX_W-1:0]  rd_addr;
    logic              row_end;
    logic              last_row;
    logic [WORD_W-1:0] prev_word;
    logic              s1_changed;
    logic [WORD_W-1:0] flat_word;

    // Handshake: the compare stage moves on when the output register is empty or its result is taken.
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_ready;
    assign o_in_stall = r_clearing || (r_s1_valid && !out_ready);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FRAME_WIDTH_RST;
            r_row_count   <= ROW_COUNT_RST;
            r_red_shift   <= RED_SHIFT_RST;
            r_green_shift <= GREEN_SHIFT_RST;
            r_blue_shift  <= BLUE_SHIFT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH: r_frame_width <= i_cfg_data[FW_W-1:0];
                CFG_ROW_COUNT:   r_row_count   <= i_cfg_data[RC_W-1:0];
                CFG_RED_SHIFT:   r_red_shift   <= i_cfg_data[SH_W-1:0];
                CFG_GREEN_SHIFT: r_green_shift <= i_cfg_data[SH_W-1:0];
                CFG_BLUE_SHIFT:  r_blue_shift  <= i_cfg_data[SH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the frame geometry to the supported range.
    always_comb begin
        if (r_frame_width < FW_W'(2)) begin
            eff_width = FW_W'(2);
        end else if (r_frame_width > FW_W'(MAX_WIDTH)) begin
            eff_width = FW_W'(MAX_WIDTH);
        end else begin
            eff_width = r_frame_width;
        end
        if (r_row_count == '0) begin
            eff_rows = RC_W'(1);
        end else if (r_row_count > RC_W'(MAX_ROWS)) begin
            eff_rows = RC_W'(MAX_ROWS);
        end else begin
            eff_rows = r_row_count;
        end
    end

    // Word index of the incoming word and end-of-row and end-of-frame tests.
    assign words_per_row = COL_W'((eff_width + FW_W'(1)) >> 1);
    assign addr_sum      = (IDX_W+1)'(r_row) * (IDX_W+1)'(words_per_row)
                         + (IDX_W+1)'(r_col[COL_W-1:1]);
    assign rd_addr       = addr_sum[IDX_W-1:0];
    assign row_end       = ({1'b0, r_col} + FW_W'(2)) >= eff_width;
    assign last_row      = ({1'b0, r_row} + RC_W'(1)) >= eff_rows;

    // Next raster position after an accepted word.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (row_end && last_row) begin
            n_col = '0;
            n_row = '0;
        end else if (row_end) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Store clearing sweep after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Store write port: the clearing sweep or a changed word leaving the compare stage.
    always_comb begin
        if (r_clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_adv && s1_changed;
            mem_waddr = r_s1.index;
            mem_wdata = r_s1.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_frame[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= mem_frame[rd_addr];
        end
    end

    // Context of the accepted word for the compare stage.
    always_comb begin
        n_s1.pixel      = i_pixel_word;
        n_s1.index      = rd_addr;
        n_s1.x          = r_col;
        n_s1.y          = r_row;
        n_s1.frame_done = row_end && last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // The stored copy of the leaving word equals its pixel whether or not it
    // is written, so a same-entry read takes that pixel. The flag drops when
    // the stage empties.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_fwd <= 1'b0;
        end else if (in_accept) begin
            r_s1_fwd <= s1_adv && (r_s1.index == rd_addr);
        end else if (s1_adv) begin
            r_s1_fwd <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1       <= n_s1;
            r_fwd_data <= r_s1.pixel;
        end
    end

    // Compare against the previous frame and repack changed words.
    assign prev_word  = r_s1_fwd ? r_fwd_data : r_rd_data;
    assign s1_changed = r_s1.pixel != prev_word;
    assign flat_word  = (r_s1.pixel == CHECKER_A || r_s1.pixel == CHECKER_B)
                      ? CHECKER_FLAT : r_s1.pixel;

    // Bounding box including the word in the compare stage.
    always_comb begin
        n_min_x = r_min_x;
        n_min_y = r_min_y;
        n_max_x = r_max_x;
        n_max_y = r_max_y;
        n_any   = r_any || s1_changed;
        if (s1_changed) begin
            if (r_s1.x < r_min_x) n_min_x = r_s1.x;
            if (r_s1.x > r_max_x) n_max_x = r_s1.x;
            if (r_s1.y < r_min_y) n_min_y = r_s1.y;
            if (r_s1.y > r_max_y) n_max_y = r_s1.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '1;
            r_min_y <= '1;
            r_max_x <= '0;
            r_max_y <= '0;
            r_any   <= 1'b0;
        end else if (s1_adv) begin
            if (r_s1.frame_done) begin
                r_min_x <= '1;
                r_min_y <= '1;
                r_max_x <= '0;
                r_max_y <= '0;
                r_any   <= 1'b0;
            end else begin
                r_min_x <= n_min_x;
                r_min_y <= n_min_y;
                r_max_x <= n_max_x;
                r_max_y <= n_max_y;
                r_any   <= n_any;
            end
        end
    end

    // Result transaction of the word in the compare stage.
    always_comb begin
        n_out.changed        = s1_changed;
        n_out.converted_word = s1_changed
                             ? repack(flat_word, r_red_shift, r_green_shift, r_blue_shift)
                             : '0;
        n_out.word_index     = r_s1.index;
        n_out.frame_done     = r_s1.frame_done;
        n_out.dirty_valid    = r_s1.frame_done && n_any;
        n_out.dirty_x0       = '0;
        n_out.dirty_y0       = '0;
        n_out.dirty_x1       = '0;
        n_out.dirty_y1       = '0;
        if (r_s1.frame_done && n_any) begin
            n_out.dirty_x0 = n_min_x;
            n_out.dirty_y0 = n_min_y;
            n_out.dirty_x1 = {1'b0, n_max_x} + 11'd2;
            n_out.dirty_y1 = {1'b0, n_max_y} + 12'd1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_changed        = r_out.changed;
    assign o_converted_word = r_out.converted_word;
    assign o_word_index     = r_out.word_index;
    assign o_frame_done     = r_out.frame_done;
    assign o_dirty_valid    = r_out.dirty_valid;
    assign o_dirty_x0       = r_out.dirty_x0;
    assign o_dirty_y0       = r_out.dirty_y0;
    assign o_dirty_x1       = r_out.dirty_x1;
    assign o_dirty_y1       = r_out.dirty_y1;

    // A word is never accepted over one that is stuck in the compare stage.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> (!r_s1_valid || s1_adv))
        else $error("input accepted while compare stage is blocked");

    // Forwarding is only armed for a word that is in the compare stage.
    a_fwd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> r_s1_valid)
        else $error("forwarding flag set without a word in the compare stage");

    // A word leaving the compare stage shows up in the output register.
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("result lost between compare stage and output register");

    // A reported rectangle is non-empty and only comes with the end of a frame.
    a_rect_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.dirty_valid) |->
            (r_out.frame_done && ({1'b0, r_out.dirty_x0} < r_out.dirty_x1)
             && ({1'b0, r_out.dirty_y0} < r_out.dirty_y1)))
        else $error("malformed dirty rectangle");

    // No word enters while the store is being cleared.
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_valid)
        else $error("word in flight during store clearing");

endmodule

`default_nettype wire

// ===== bench/frame_diff_dirty_rect_unit_test.sv =====
module frame_diff_dirty_rect_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fddr_pkg::*;

    localparam int RANDOM_WORDS = 380;
    localparam int STALL_PCT    = 31;
    localparam int REPORT_LIMIT = 10;

    // Register indexes past the end of the register list; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_MID = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI  = 3'd7;

    // One line of the directed script: a register write or an input word.
    typedef struct packed {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [WORD_W-1:0]     word;
        bit                    has_known;
        t_result               known;
    } t_script_line;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [WORD_W-1:0]     i_pixel_word = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_changed;
    logic [WORD_W-1:0]     o_converted_word;
    logic [IDX_W-1:0]      o_word_index;
    logic                  o_frame_done;
    logic                  o_dirty_valid;
    logic [9:0]            o_dirty_x0;
    logic [10:0]           o_dirty_y0;
    logic [10:0]           o_dirty_x1;
    logic [11:0]           o_dirty_y1;

    frame_diff_dirty_rect_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pixel_word     (i_pixel_word),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_changed        (o_changed),
        .o_converted_word (o_converted_word),
        .o_word_index     (o_word_index),
        .o_frame_done     (o_frame_done),
        .o_dirty_valid    (o_dirty_valid),
        .o_dirty_x0       (o_dirty_x0),
        .o_dirty_y0       (o_dirty_y0),
        .o_dirty_x1       (o_dirty_x1),
        .o_dirty_y1       (o_dirty_y1)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the registers and the frame tracking state.
    int unsigned cfg_width = FRAME_WIDTH_RST;
    int unsigned cfg_rows  = ROW_COUNT_RST;
    int unsigned sh_red    = RED_SHIFT_RST;
    int unsigned sh_green  = GREEN_SHIFT_RST;
    int unsigned sh_blue   = BLUE_SHIFT_RST;
    bit [31:0]   prev_words [0:1048575];
    int unsigned col, row, min_x, min_y, max_x, max_y;
    bit          seen_change;

    t_result      word_reports [$];
    t_script_line script [$];

    bit steady = 1'b0;
    int failures = 0;
    int results_checked = 0;
    int words_sent = 0;
    int frames_closed = 0;
    int rects_seen = 0;
    int words_changed = 0;
    int reg_writes = 0;

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < STALL_PCT);
    endfunction

    function automatic void restart_frame();
        col = 0;
        row = 0;
        min_x = 32'h3FF;
        min_y = 32'h7FF;
        max_x = 0;
        max_y = 0;
        seen_change = 1'b0;
    endfunction

    function automatic int unsigned clamped_width();
        if (cfg_width < 2) return 2;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    // Store address of the word at the current raster position.
    function automatic int unsigned word_addr();
        return (row * ((clamped_width() + 1) / 2) + col / 2) & 32'hF_FFFF;
    endfunction

    // Compare one word with the stored frame, repack it and grow the dirty box.
    function automatic t_result diff_word(input logic [WORD_W-1:0] pixel);
        int unsigned w, nrows, x, y, addr, x_end, y_end;
        logic [WORD_W-1:0] p;
        bit row_end, last;
        t_result r;
        w = clamped_width();
        nrows = (cfg_rows < 1) ? 1 : ((cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows);
        x = col;
        y = row;
        addr = word_addr();
        r = '0;
        r.word_index = addr[19:0];
        if (pixel != prev_words[addr]) begin
            prev_words[addr] = pixel;
            // Both checkerboard words collapse to one flat pattern.
            p = (pixel == CHECKER_A || pixel == CHECKER_B) ? CHECKER_FLAT : pixel;
            r.changed = 1'b1;
            r.converted_word = ((p >> sh_red) & 32'h001F_001F)
                             | (((p >> sh_green) & 32'h001F_001F) << 5)
                             | (((p >> sh_blue) & 32'h001F_001F) << 10);
            if (x < min_x) min_x = x;
            if (x > max_x) max_x = x;
            if (y < min_y) min_y = y;
            if (y > max_y) max_y = y;
            seen_change = 1'b1;
        end
        row_end = (x + 2 >= w);
        last = row_end && (y + 1 >= nrows);
        r.frame_done = last;
        if (last && seen_change) begin
            x_end = max_x + 2;
            y_end = max_y + 1;
            r.dirty_valid = 1'b1;
            r.dirty_x0 = min_x[9:0];
            r.dirty_y0 = min_y[10:0];
            r.dirty_x1 = x_end[10:0];
            r.dirty_y1 = y_end[11:0];
        end
        // Advance the raster position; a finished frame starts over.
        if (last) begin
            restart_frame();
        end else if (row_end) begin
            col = 0;
            row = (y + 1) & 32'h7FF;
        end else begin
            col = (x + 2) & 32'h3FF;
        end
        return r;
    endfunction

    function automatic t_result plain_report(input bit chg, input logic [WORD_W-1:0] conv,
                                             input logic [IDX_W-1:0] idx, input bit done);
        t_result r;
        r = '0;
        r.changed = chg;
        r.converted_word = conv;
        r.word_index = idx;
        r.frame_done = done;
        return r;
    endfunction

    function automatic void show(input string tag, input t_result r);
        $display("    %s changed=%0d word=%08h index=%0d done=%0d dirty=%0d box=(%0d,%0d)-(%0d,%0d)",
                 tag, r.changed, r.converted_word, r.word_index, r.frame_done,
                 r.dirty_valid, r.dirty_x0, r.dirty_y0, r.dirty_x1, r.dirty_y1);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_shift();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) return 12'd0;
        if (pick < 40) return 12'd31;
        return CFG_DATA_W'($urandom_range(0, 31));
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_script_line s;
        s = '0;
        s.is_reg = 1'b1;
        s.reg_idx = idx;
        s.reg_data = data;
        script.push_back(s);
    endfunction

    function automatic void add_word(input logic [WORD_W-1:0] w);
        t_script_line s;
        s = '0;
        s.word = w;
        script.push_back(s);
    endfunction

    function automatic void add_known(input logic [WORD_W-1:0] w, input t_result res);
        t_script_line s;
        s = '0;
        s.word = w;
        s.has_known = 1'b1;
        s.known = res;
        script.push_back(s);
    endfunction

    // Hold the input off until every outstanding result has come back.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (word_reports.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH: cfg_width = data[10:0];
            CFG_ROW_COUNT:   cfg_rows = data;
            CFG_RED_SHIFT:   sh_red = data[4:0];
            CFG_GREEN_SHIFT: sh_green = data[4:0];
            CFG_BLUE_SHIFT:  sh_blue = data[4:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Offer one word, wait for the transaction, then queue its expected result.
    task automatic push_word(input logic [WORD_W-1:0] w, input bit use_known,
                             input t_result known);
        t_result predicted;
        @(negedge i_clk);
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_pixel_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = diff_word(w);
        word_reports.push_back(use_known ? known : predicted);
        words_sent++;
        if (predicted.changed) words_changed++;
        if (predicted.frame_done) frames_closed++;
        if (predicted.dirty_valid) rects_seen++;
    endtask

    // The receiver stalls at random except during the steady stretch.
    always @(negedge i_clk) begin
        i_out_stall <= take_break();
    end

    // Check each result transaction against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_changed, o_converted_word, o_word_index, o_frame_done, o_dirty_valid,
                   o_dirty_x0, o_dirty_y0, o_dirty_x1, o_dirty_y1};
            results_checked++;
            if (word_reports.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("[%0t] result with nothing expected:", $realtime);
                    show("got ", got);
                end
            end else begin
                want = word_reports.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= REPORT_LIMIT) begin
                        $display("[%0t] result mismatch:", $realtime);
                        show("want", want);
                        show("got ", got);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int directed_words, random_done, spin, count, span;
        int unsigned pick, w_pick, r_pick;
        logic [WORD_W-1:0] pal [0:3];
        logic [WORD_W-1:0] w, rnd;
        logic [CFG_IDX_W-1:0] spare;

        restart_frame();

        // Reset settings: a word equal to the cleared store, then all ones.
        add_known(32'h0000_0000, plain_report(1'b0, 32'h0, 20'd0, 1'b0));
        add_known(32'hFFFF_FFFF, plain_report(1'b1, 32'h7FFF_7FFF, 20'd1, 1'b0));
        // Width and row count below range, mid-row: the row and the frame end at once.
        add_reg(CFG_FRAME_WIDTH, 12'd0);
        add_reg(CFG_ROW_COUNT, 12'd0);
        // Writes past the register list must leave everything alone.
        add_reg(CFG_NONE_LO, 12'hFFF);
        add_reg(CFG_NONE_MID, 12'h000);
        add_reg(CFG_NONE_HI, 12'hAAA);
        add_word(32'h1234_5678);
        // Width and row count above range, shift extremes, both checkerboards.
        add_reg(CFG_FRAME_WIDTH, 12'd2047);
        add_reg(CFG_ROW_COUNT, 12'd4095);
        add_reg(CFG_RED_SHIFT, 12'd31);
        add_reg(CFG_GREEN_SHIFT, 12'd0);
        add_reg(CFG_BLUE_SHIFT, 12'd31);
        add_word(CHECKER_A);
        add_word(CHECKER_B);
        add_word(32'h8000_0001);
        add_word(32'h7FFF_FFFE);
        add_word(32'hFFFF_FFFF);
        add_word(32'hFFFF_FFFF);
        // Shrink the frame under the current position: the next word closes it.
        add_reg(CFG_FRAME_WIDTH, 12'd6);
        add_reg(CFG_ROW_COUNT, 12'd1);
        add_word(32'h0000_0000);
        // Odd width, two rows; the second pass over the same frame is clean.
        add_reg(CFG_FRAME_WIDTH, 12'd3);
        add_reg(CFG_ROW_COUNT, 12'd2);
        add_reg(CFG_RED_SHIFT, 12'd1);
        add_reg(CFG_GREEN_SHIFT, 12'd17);
        add_reg(CFG_BLUE_SHIFT, 12'd25);
        add_word(32'hDEAD_BEEF);
        add_word(32'h0F0F_0F0F);
        add_word(32'h0000_0000);
        add_word(32'hFFFF_0000);
        add_word(32'hDEAD_BEEF);
        add_word(32'h0F0F_0F0F);
        add_word(32'h0000_0000);
        add_known(32'hFFFF_0000, plain_report(1'b0, 32'h0, 20'd3, 1'b1));

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed script.
        for (int i = 0; i < script.size(); i++) begin
            if (script[i].is_reg) begin
                write_reg(script[i].reg_idx, script[i].reg_data);
            end else begin
                push_word(script[i].word, script[i].has_known, script[i].known);
            end
        end
        directed_words = words_sent;

        // Random settings, each followed by a few frames or a cut-off partial frame.
        random_done = 0;
        while (random_done < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) w_pick = $urandom_range(2, 12);
            else if (pick < 80) w_pick = $urandom_range(0, 40);
            else w_pick = $urandom_range(41, 2047);
            pick = $urandom_range(0, 99);
            if (pick < 70) r_pick = $urandom_range(1, 5);
            else if (pick < 85) r_pick = $urandom_range(0, 12);
            else r_pick = $urandom_range(13, 4095);
            write_reg(CFG_FRAME_WIDTH, w_pick[11:0]);
            write_reg(CFG_ROW_COUNT, r_pick[11:0]);
            write_reg(CFG_RED_SHIFT, pick_shift());
            write_reg(CFG_GREEN_SHIFT, pick_shift());
            write_reg(CFG_BLUE_SHIFT, pick_shift());
            if ($urandom_range(0, 7) == 0) begin
                spare = CFG_IDX_W'($urandom_range(CFG_NONE_LO, CFG_NONE_HI));
                rnd = $urandom;
                write_reg(spare, rnd[11:0]);
            end

            span = ((w_pick + 1) / 2) * ((r_pick == 0) ? 1 : r_pick);
            count = span * $urandom_range(1, 3);
            if (count > 48 || count == 0) count = $urandom_range(8, 48);
            for (int k = 0; k < 4; k++) pal[k] = $urandom;

            // Mostly repeated frames with sparse edits so the boxes stay interesting.
            for (int k = 0; k < count; k++) begin
                steady = (random_done >= 120 && random_done < 200);
                pick = $urandom_range(0, 99);
                if (pick < 40) w = prev_words[word_addr()];
                else if (pick < 65) w = pal[$urandom_range(0, 3)];
                else if (pick < 75) w = pick[0] ? CHECKER_A : CHECKER_B;
                else w = $urandom;
                push_word(w, 1'b0, '0);
                random_done++;
            end
        end
        steady = 1'b0;

        // Drain the remaining results, with a bound.
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        spin = 0;
        while (word_reports.size() != 0 && spin < 20000) begin
            @(negedge i_clk);
            spin++;
        end
        repeat (8) @(negedge i_clk);
        if (word_reports.size() != 0) begin
            $display("%0d expected results never arrived", word_reports.size());
            failures += word_reports.size();
        end

        $display("Covered %0d words (%0d directed) and %0d register writes; %0d results checked.",
                 words_sent, directed_words, reg_writes, results_checked);
        $display("%0d frames closed, %0d with a dirty rectangle; %0d words changed; %0d failures.",
                 frames_closed, rects_seen, words_changed, failures);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Covers the store clearing pass after reset several times over.
    initial begin : watchdog
        #(20_000_000);
        $display("Run did not finish in time.");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== frame_diff_dirty_rect_unit.f =====
rtl/fddr_pkg.sv
rtl/frame_diff_dirty_rect_unit.sv
bench/frame_diff_dirty_rect_unit_test.sv
